// ===== hdl/ssq_pkg.sv =====
package ssq_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int TAG_W    = 16;
   localparam int PRIO_W   = 16;

   typedef enum logic {
      CMD_INSERT  = 1'b0,
      CMD_READOUT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_ENTRY    = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]         tag;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic       insert;
      logic       rotate;
      entry_type  fresh;
      logic [CNT_W-1:0] count;
   } cell_ctl_type;

endpackage

// ===== hdl/ssq_req_if.sv =====
interface ssq_req_if;
   import ssq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [TAG_W-1:0]         tag;
   logic signed [PRIO_W-1:0] priority_req;

   modport source (output valid, output cmd, output tag, output priority_req, input ready);
   modport sink   (input valid, input cmd, input tag, input priority_req, output ready);
endinterface

// ===== hdl/ssq_rsp_if.sv =====
interface ssq_rsp_if;
   import ssq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [TAG_W-1:0]         out_tag;
   logic signed [PRIO_W-1:0] out_priority;
   logic [1:0]               status;
   logic                     last;

   modport source (output valid, output out_tag, output out_priority, output status,
                   output last, input ready);
   modport sink   (input valid, input out_tag, input out_priority, input status,
                   input last, output ready);
endinterface

// ===== hdl/ssq_cell.sv =====
module ssq_cell (
   input  logic                        clock,
   input  logic [ssq_pkg::CNT_W-1:0]   cell_idx,
   input  ssq_pkg::cell_ctl_type       ctl,
   input  logic                        prev_keep,
   input  ssq_pkg::entry_type          prev_entry,
   input  ssq_pkg::entry_type          next_entry,
   input  ssq_pkg::entry_type          head_entry,
   output logic                        keep,
   output ssq_pkg::entry_type          entry
);
   import ssq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      occ;
   logic      next_occ;

   assign occ      = cell_idx < ctl.count;
   assign next_occ = (CNT_W'(cell_idx + 1'b1)) < ctl.count;
   // equal priority stays ahead of the newcomer
   assign keep     = occ && (entry_ff.prio >= ctl.fresh.prio);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = ctl.fresh;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctl.rotate && occ) begin
         // tail of the occupied run picks up the head: rotation restores order
         entry_in = next_occ ? next_entry : head_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule

// ===== hdl/stable_sorted_priority_queue_unit.sv =====
// Stable sorted priority queue, built as a row of CAPACITY cells.
// req_chan (valid/ready): cmd selects insert or readout; tag and
//   priority_req give the entry to insert. A word is taken on valid && ready.
// rsp_chan (valid/ready): out_tag, out_priority, status, last.
// Insert: every cell compares its priority with the new one in the same
//   cycle and either holds, takes the new entry or takes its left
//   neighbour's; one status word appears in the cycle after acceptance.
//   Equal priorities keep arrival order. A full store drops the entry.
// Readout: acceptance moves the unit to the read state; then, while the output
//   register is free, the occupied cells rotate one place per cycle towards
//   cell 0, cell 0 feeding the output register, so all stored entries leave in
//   turn and the store is back in order afterwards. An empty store gives one word.
// Throughput: one insert per cycle while the output register is free; a readout
//   holds off new requests until its last word is in the output register.
// Responses: the status word of an insert or of an empty readout appears in the
//   cycle after acceptance; a readout loads its first word in the read state.
// Receiver stall: the output register holds its word and the chain stops;
//   req_chan.ready drops while the output register is full and not taken.
// Reset (synchronous): empties the store and the output register; the entry
//   storage itself is not cleared.
module stable_sorted_priority_queue_unit (
   input  logic      clock,
   input  logic      reset,
   ssq_req_if.sink   req_chan,
   ssq_rsp_if.source rsp_chan
);
   import ssq_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] remain_ff, remain_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]         rsp_tag_ff, rsp_tag_in;
   logic signed [PRIO_W-1:0] rsp_prio_ff, rsp_prio_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic         out_free;
   logic         accept;
   logic         is_insert;
   logic         is_full;
   logic         rd_last;
   cell_ctl_type ctl;

   entry_type cell_entry [CAPACITY];
   logic      cell_keep  [CAPACITY];

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_chan.ready;
   assign is_insert = req_chan.cmd == CMD_INSERT;
   assign is_full   = count_ff == CNT_W'(CAPACITY);
   assign rd_last   = remain_ff == CNT_W'(1);

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !is_insert && count_ff != '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free && rd_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- control outputs
   always_comb begin
      req_chan.ready  = 1'b0;
      ctl.rotate      = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_chan.ready = out_free;
         ST_READ: ctl.rotate     = out_free;
         default: ;
      endcase
      ctl.insert     = accept && is_insert && !is_full;
      ctl.fresh.tag  = req_chan.tag;
      ctl.fresh.prio = req_chan.priority_req;
      ctl.count      = count_ff;
   end

   // ---- cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      p_keep;
      entry_type p_entry;
      entry_type n_entry;
      if (i == 0) begin : g_first
         assign p_keep  = 1'b1;
         assign p_entry = ctl.fresh;
      end else begin : g_mid
         assign p_keep  = cell_keep[i-1];
         assign p_entry = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign n_entry = cell_entry[0];
      end else begin : g_body
         assign n_entry = cell_entry[i+1];
      end
      ssq_cell u_cell (
         .clock      (clock),
         .cell_idx   (CNT_W'(i)),
         .ctl        (ctl),
         .prev_keep  (p_keep),
         .prev_entry (p_entry),
         .next_entry (n_entry),
         .head_entry (cell_entry[0]),
         .keep       (cell_keep[i]),
         .entry      (cell_entry[i])
      );
   end

   // ---- counters and output register
   always_comb begin
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.insert) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_tag_in   = '0;
         rsp_prio_in  = '0;
         rsp_last_in  = 1'b1;
         if (is_insert) begin
            rsp_status_in = is_full ? STATUS_FULL : STATUS_INSERTED;
         end else if (count_ff == '0) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            // first entry goes out on the next cycle
            rsp_valid_in = 1'b0;
            remain_in    = count_ff;
         end
      end else if (ctl.rotate) begin
         rsp_valid_in  = 1'b1;
         rsp_tag_in    = cell_entry[0].tag;
         rsp_prio_in   = cell_entry[0].prio;
         rsp_status_in = STATUS_ENTRY;
         rsp_last_in   = rd_last;
         remain_in     = CNT_W'(remain_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_tag      = rsp_tag_ff;
   assign rsp_chan.out_priority = rsp_prio_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("insert did not add an entry");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> $stable(count_ff) && remain_ff != '0
                              && remain_ff <= count_ff)
      else $error("readout bookkeeping broken");

   a_no_req_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !req_chan.ready)
      else $error("request taken during readout");

   a_last_leaves_read: assert property (@(posedge clock) disable iff (reset)
      ctl.rotate && rd_last |=> state_ff == ST_IDLE && rsp_chan.last)
      else $error("readout did not end on last word");
`endif
endmodule
